[hdl/iate_pkg.sv]
// Shared types, sizes and codes for the indexed array table engine.
package iate_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Request modes.
  localparam logic [2:0] MODE_INSERT   = 3'd0;
  localparam logic [2:0] MODE_DELETE   = 3'd1;
  localparam logic [2:0] MODE_TRAVERSE = 3'd2;
  localparam logic [2:0] MODE_SEARCH   = 3'd3;
  localparam logic [2:0] MODE_UPDATE   = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Operations applied to the whole row of cells.
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_ROTATE = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [CNT_W-1:0]  count;
  } cell_cmd_t;

endpackage

[hdl/iate_cell.sv]
// One storage cell of the list: holds one entry and trades it with its neighbors.
module iate_cell (
  input  logic                        clk,
  input  iate_pkg::cell_cmd_t         cmd,
  input  logic [iate_pkg::IDX_W-1:0]  cell_index,
  input  logic [iate_pkg::DATA_W-1:0] left_in,
  input  logic [iate_pkg::DATA_W-1:0] right_in,
  input  logic [iate_pkg::DATA_W-1:0] wrap_in,
  output logic [iate_pkg::DATA_W-1:0] entry,
  output logic                        match
);
  import iate_pkg::*;

  logic [CNT_W-1:0]  my_idx;
  logic [CNT_W-1:0]  my_idx_plus;
  logic [DATA_W-1:0] entry_next;

  assign my_idx      = CNT_W'(cell_index);
  assign my_idx_plus = my_idx + CNT_W'(1);

  // Only cells below the count hold live entries.
  assign match = (entry == cmd.val) && (my_idx < cmd.count);

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      OP_INSERT: begin
        if (my_idx > cmd.pos) begin
          entry_next = left_in;
        end else if (my_idx == cmd.pos) begin
          entry_next = cmd.val;
        end
      end
      OP_DELETE: begin
        if (my_idx >= cmd.pos) begin
          entry_next = right_in;
        end
      end
      OP_UPDATE: begin
        if (my_idx == cmd.pos) begin
          entry_next = cmd.val;
        end
      end
      OP_ROTATE: begin
        // The live part of the row turns by one, the head going to the tail.
        if (my_idx_plus < cmd.count) begin
          entry_next = right_in;
        end else if (my_idx_plus == cmd.count) begin
          entry_next = wrap_in;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[hdl/indexed_array_table_engine_core.sv]
// Top level of the indexed array table engine: request control and the row of cells.
//
// Requests arrive on the s_axis channel, one item per request: mode, position
// and value packed in s_axis_tdata. Results leave on m_axis, one item each, with
// tlast on the final result of a request. Insert, delete and update shift or
// write every cell at once and give their one result from the input register
// through the output register. Search also registers the match vector: the
// cells compare in parallel, the match vector is registered and then priority
// encoded. Traverse turns the live part of the cell row by one position per
// result, reading the head cell, so it gives count results at one per cycle
// while the receiver takes them and leaves the order as it was. A one-item
// input register lets the next request in while the block still works or a
// result waits, but takes no new request while it is full; a new request is
// started only once the previous one has delivered all results. Reset clears
// the count, the control state and both valid flags; the cell contents are
// left as they are and are read only once written. When the receiver holds
// m_axis_tready low the result stays in place, a traversal pauses with the row
// frozen, and s_axis_tready drops once the input register is full.
module indexed_array_table_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] mode, [7:3] position, [39:8] data_value
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [7:3] result_index, [39:8] result_value, [45:40] entry_count
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import iate_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_TRAV   = 2'd2;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    trav_idx, trav_idx_next;

  logic                hold_valid;
  logic [2:0]          hold_mode;
  logic [4:0]          hold_pos;
  logic [DATA_W-1:0]   hold_val;
  logic                hold_clear;
  logic                in_fire;

  logic                out_valid;
  logic [2:0]          out_status;
  logic [IDX_W-1:0]    out_index;
  logic [DATA_W-1:0]   out_value;
  logic                out_last;
  logic [CNT_W-1:0]    out_count;
  logic                out_free;

  logic                emit;
  logic [2:0]          e_status;
  logic [IDX_W-1:0]    e_index;
  logic [DATA_W-1:0]   e_value;
  logic                e_last;

  logic                match_load;
  logic [CAPACITY-1:0] match_bits;
  logic [CAPACITY-1:0] match_reg;
  logic                found;
  logic [IDX_W-1:0]    found_idx;

  cell_cmd_t           cmd;
  logic [DATA_W-1:0]   entries [CAPACITY];
  logic [CNT_W-1:0]    pos_ext;

  assign in_fire       = s_axis_tvalid && !hold_valid;
  assign s_axis_tready = !hold_valid;
  assign out_free      = !out_valid || m_axis_tready;
  assign pos_ext       = CNT_W'(hold_pos);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      if (gi == 0) begin : g_head
        assign left_w = entries[gi];
      end else begin : g_mid
        assign left_w = entries[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign right_w = entries[gi];
      end else begin : g_body
        assign right_w = entries[gi+1];
      end
      iate_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cell_index (IDX_W'(gi)),
        .left_in    (left_w),
        .right_in   (right_w),
        .wrap_in    (entries[0]),
        .entry      (entries[gi]),
        .match      (match_bits[gi])
      );
    end
  endgenerate

  // Lowest matching index wins.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match_reg[k]) begin
        found     = 1'b1;
        found_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    cmd.op        = OP_HOLD;
    cmd.pos       = pos_ext;
    cmd.val       = hold_val;
    cmd.count     = count;
    state_next    = state;
    count_next    = count;
    trav_idx_next = trav_idx;
    hold_clear    = 1'b0;
    match_load    = 1'b0;
    emit          = 1'b0;
    e_status      = ST_OK;
    e_index       = '0;
    e_value       = '0;
    e_last        = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (hold_valid && out_free) begin
          hold_clear = 1'b1;
          unique case (hold_mode)
            MODE_INSERT: begin
              emit = 1'b1;
              if (count >= CNT_W'(CAPACITY)) begin
                e_status = ST_FULL;
              end else if (pos_ext > count) begin
                e_status = ST_BADPOS;
              end else begin
                cmd.op     = OP_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            MODE_DELETE: begin
              emit = 1'b1;
              if (count == '0) begin
                e_status = ST_EMPTY;
              end else if (pos_ext >= count) begin
                e_status = ST_BADPOS;
              end else begin
                cmd.op     = OP_DELETE;
                count_next = count - CNT_W'(1);
              end
            end
            MODE_UPDATE: begin
              emit = 1'b1;
              if (count == '0) begin
                e_status = ST_EMPTY;
              end else if (pos_ext >= count) begin
                e_status = ST_BADPOS;
              end else begin
                cmd.op = OP_UPDATE;
              end
            end
            MODE_SEARCH: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                match_load = 1'b1;
                state_next = S_SEARCH;
              end
            end
            MODE_TRAVERSE: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                trav_idx_next = '0;
                state_next    = S_TRAV;
              end
            end
            default: begin
              // Unused modes are dropped without a result.
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = found ? ST_OK : ST_NOTFOUND;
          e_index    = found ? found_idx : '0;
          state_next = S_IDLE;
        end
      end
      S_TRAV: begin
        if (out_free) begin
          emit          = 1'b1;
          cmd.op        = OP_ROTATE;
          e_index       = trav_idx;
          e_value       = entries[0];
          e_last        = (CNT_W'(trav_idx) == count - CNT_W'(1));
          trav_idx_next = trav_idx + IDX_W'(1);
          if (e_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (in_fire) begin
        hold_valid <= 1'b1;
      end else if (hold_clear) begin
        hold_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    trav_idx <= trav_idx_next;
    if (in_fire) begin
      hold_mode <= s_axis_tdata[2:0];
      hold_pos  <= s_axis_tdata[7:3];
      hold_val  <= s_axis_tdata[39:8];
    end
    if (match_load) begin
      match_reg <= match_bits;
    end
    if (emit) begin
      out_status <= e_status;
      out_index  <= e_index;
      out_value  <= e_value;
      out_last   <= e_last;
      out_count  <= count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_count, out_value, out_index, out_status};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_trav_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRAV) |-> (CNT_W'(trav_idx) < count))
    else $error("traversal index past the live entries");

  a_nonlast_in_trav: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (state == S_TRAV))
    else $error("non-final result outside a traversal");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count)))
    else $error("count changed during a multi-cycle request");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the indexed array table engine: directed table, then random requests.
module tb_top;
  import iate_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 245;
  localparam int QUIET_TAIL    = 40;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [2:0]        status;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic              last;
    logic [CNT_W-1:0]  count;
  } table_result_t;

  typedef struct {
    logic [2:0]        mode;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                typed;
    logic [2:0]        status;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic [DATA_W-1:0] table_entries [CAPACITY];
  int                table_count;
  table_result_t     step_results [$];
  table_result_t     pending_results [$];
  directed_row_t     directed_rows [DIRECTED_ROWS];
  int                failures;
  int                idle_cycles;
  int                stall_left;
  bit                quiet;
  bit                growing;

  indexed_array_table_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void add_result(logic [2:0] st, logic [IDX_W-1:0] idx,
                                     logic [DATA_W-1:0] v, logic lst);
    step_results.push_back('{st, idx, v, lst, table_count[CNT_W-1:0]});
  endfunction

  // Applies one request to the table copy and collects the results it causes.
  task automatic predict_request(input logic [2:0] mode, input logic [IDX_W-1:0] pos,
                                 input logic [DATA_W-1:0] val);
    bit hit;
    step_results.delete();
    hit = 1'b0;
    case (mode)
      MODE_INSERT: begin
        if (table_count >= CAPACITY) add_result(ST_FULL, '0, '0, 1'b1);
        else if (pos > table_count) add_result(ST_BADPOS, '0, '0, 1'b1);
        else begin
          for (int i = table_count; i > pos; i--) table_entries[i] = table_entries[i-1];
          table_entries[pos] = val;
          table_count++;
          add_result(ST_OK, '0, '0, 1'b1);
        end
      end
      MODE_DELETE, MODE_UPDATE: begin
        if (table_count == 0) add_result(ST_EMPTY, '0, '0, 1'b1);
        else if (pos >= table_count) add_result(ST_BADPOS, '0, '0, 1'b1);
        else begin
          if (mode == MODE_UPDATE) begin
            table_entries[pos] = val;
          end else begin
            for (int i = pos; i + 1 < table_count; i++) table_entries[i] = table_entries[i+1];
            table_count--;
          end
          add_result(ST_OK, '0, '0, 1'b1);
        end
      end
      MODE_TRAVERSE: begin
        if (table_count == 0) add_result(ST_EMPTY, '0, '0, 1'b1);
        else
          for (int i = 0; i < table_count; i++)
            add_result(ST_OK, i[IDX_W-1:0], table_entries[i], i + 1 == table_count);
      end
      MODE_SEARCH: begin
        if (table_count == 0) add_result(ST_EMPTY, '0, '0, 1'b1);
        else begin
          for (int i = 0; i < table_count; i++) begin
            if (!hit && table_entries[i] == val) begin
              hit = 1'b1;
              add_result(ST_OK, i[IDX_W-1:0], '0, 1'b1);
            end
          end
          if (!hit) add_result(ST_NOTFOUND, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // Drives one request from a falling edge and returns at the falling edge after its accept.
  task automatic send_request(input logic [2:0] mode, input logic [IDX_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input bit typed,
                              input table_result_t typed_result, input bit drain_first);
    if (drain_first && pending_results.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while (pending_results.size() != 0);
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tdata  <= {val, pos, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_request(mode, pos, val);
    if (typed) pending_results.push_back(typed_result);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom_range(0, 7));
      1: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'hffff_ffff;
           default: return 32'h0;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] expv,
                                      logic [DATA_W-1:0] act);
    if (act !== expv) begin
      $error("%s: expected %0h, actual %0h", name, expv, act);
      failures++;
    end
  endfunction

  // Receiver side: m_axis_tready drops at random, with no new stalls started in the quiet tail.
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && !rst && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
    m_axis_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin : result_monitor
    table_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(m_axis_tdata[2:0]));
        check_field("result_index", DATA_W'(want.index), DATA_W'(m_axis_tdata[7:3]));
        check_field("result_value", want.value, m_axis_tdata[39:8]);
        check_field("entry_count", DATA_W'(want.count), DATA_W'(m_axis_tdata[45:40]));
        check_field("last", DATA_W'(want.last), DATA_W'(m_axis_tlast));
      end
    end
  end

  // Ends the run when neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [2:0]        mode;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int                pick;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    growing       = 1'b1;
    table_count   = 0;

    // Rows flagged as typed carry their one result; the others go through the predictor.
    directed_rows = '{
      '{MODE_DELETE,   5'd0,  32'h0,         1'b1, ST_EMPTY,    5'd0, 6'd0},
      '{MODE_TRAVERSE, 5'd0,  32'h0,         1'b1, ST_EMPTY,    5'd0, 6'd0},
      '{MODE_SEARCH,   5'd0,  32'h5,         1'b1, ST_EMPTY,    5'd0, 6'd0},
      '{MODE_UPDATE,   5'd0,  32'h1,         1'b1, ST_EMPTY,    5'd0, 6'd0},
      '{MODE_INSERT,   5'd1,  32'h1,         1'b1, ST_BADPOS,   5'd0, 6'd0},
      '{MODE_INSERT,   5'd0,  32'h8000_0000, 1'b1, ST_OK,       5'd0, 6'd1},
      '{MODE_INSERT,   5'd1,  32'h7fff_ffff, 1'b1, ST_OK,       5'd0, 6'd2},
      '{MODE_INSERT,   5'd0,  32'hffff_ffff, 1'b1, ST_OK,       5'd0, 6'd3},
      '{MODE_INSERT,   5'd31, 32'h0,         1'b1, ST_BADPOS,   5'd0, 6'd3},
      '{MODE_SEARCH,   5'd0,  32'h7fff_ffff, 1'b1, ST_OK,       5'd2, 6'd3},
      '{MODE_SEARCH,   5'd0,  32'h0,         1'b1, ST_NOTFOUND, 5'd0, 6'd3},
      '{MODE_UPDATE,   5'd3,  32'h0,         1'b1, ST_BADPOS,   5'd0, 6'd3},
      '{MODE_UPDATE,   5'd1,  32'h0,         1'b1, ST_OK,       5'd0, 6'd3},
      '{MODE_SEARCH,   5'd31, 32'h0,         1'b1, ST_OK,       5'd1, 6'd3},
      '{MODE_UNUSED_LO, 5'd0, 32'h0,         1'b0, ST_OK,       5'd0, 6'd0},
      '{MODE_UNUSED_HI, 5'd31, 32'hffff_ffff, 1'b0, ST_OK,      5'd0, 6'd0},
      '{MODE_TRAVERSE, 5'd0,  32'h0,         1'b0, ST_OK,       5'd0, 6'd0},
      '{MODE_DELETE,   5'd3,  32'h0,         1'b1, ST_BADPOS,   5'd0, 6'd3},
      '{MODE_DELETE,   5'd31, 32'h0,         1'b1, ST_BADPOS,   5'd0, 6'd3},
      '{MODE_DELETE,   5'd2,  32'h0,         1'b1, ST_OK,       5'd0, 6'd2},
      '{MODE_DELETE,   5'd0,  32'h0,         1'b1, ST_OK,       5'd0, 6'd1},
      '{MODE_TRAVERSE, 5'd0,  32'h0,         1'b0, ST_OK,       5'd0, 6'd0},
      '{MODE_INSERT,   5'd1,  32'h5555_aaaa, 1'b1, ST_OK,       5'd0, 6'd2},
      '{MODE_UNUSED_MID, 5'd2, 32'h1234_5678, 1'b0, ST_OK,      5'd0, 6'd0},
      '{MODE_SEARCH,   5'd0,  32'h5555_aaaa, 1'b1, ST_OK,       5'd1, 6'd2}
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r])
      send_request(directed_rows[r].mode, directed_rows[r].pos, directed_rows[r].val,
                   directed_rows[r].typed,
                   '{directed_rows[r].status, directed_rows[r].index, '0, 1'b1,
                     directed_rows[r].count},
                   r == DIRECTED_ROWS - 1);

    // The table swings between filling up and draining so that both ends are hit often.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
      if (growing && table_count == CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
      else if (!growing && table_count == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) mode = growing ? MODE_INSERT : MODE_DELETE;
      else if (pick < 78) mode = growing ? MODE_DELETE : MODE_INSERT;
      else if (pick < 85) mode = MODE_SEARCH;
      else if (pick < 91) mode = MODE_UPDATE;
      else if (pick < 96) mode = MODE_TRAVERSE;
      else mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));

      pos = IDX_W'($urandom_range(0, CAPACITY - 1));
      if ($urandom_range(0, 99) < 85) begin
        if (mode == MODE_INSERT) pos = IDX_W'($urandom_range(0, table_count));
        else if (table_count > 0) pos = IDX_W'($urandom_range(0, table_count - 1));
      end

      val = pick_value();
      if (mode == MODE_SEARCH && table_count > 0 && $urandom_range(0, 9) < 6)
        val = table_entries[$urandom_range(0, table_count - 1)];

      send_request(mode, pos, val, 1'b0, '0, n == 60 || n == 150);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
